// ----- design/assert_macros.svh -----
// Assertion macros shared by the compositor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed: label");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed: label");
`endif

// ----- design/mcc_pkg.sv -----
// Shared types and constants of the mosaic canvas compositor.
package mcc_pkg;
   localparam int CANVAS_SIDE = 256;
   localparam int SIDE_W = $clog2(CANVAS_SIDE);
   localparam int CELL_W = 2 * SIDE_W;
   localparam int CELLS = CANVAS_SIDE * CANVAS_SIDE;
   localparam int ORIGIN = CANVAS_SIDE / 2;
   localparam logic [1:0] OP_COMPOSITE = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ = 2'd3;
   localparam logic CSR_FRAME_WIDTH = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   // Classified command handed from the front to the back part.
   typedef struct packed {
      logic [1:0] op;
      logic       write_px;   // composite that lands inside canvas and frame
      logic       on_canvas;
      logic [CELL_W-1:0] cell_addr;
      logic [23:0] colour;    // red, green, blue from high to low
      logic       box_upd;    // last pixel of a frame meeting the canvas
      logic signed [16:0] px;
      logic signed [16:0] py;
      logic signed [16:0] fx1;
      logic signed [16:0] fy1;
      logic [SIDE_W:0] x0;    // clipped rectangle, end exclusive
      logic [SIDE_W:0] y0;
      logic [SIDE_W:0] x1;
      logic [SIDE_W:0] y1;
      logic       clip_ok;
   } cmd_type;

   typedef struct packed {
      logic signed [16:0] min_x;
      logic signed [16:0] min_y;
      logic signed [16:0] max_x;
      logic signed [16:0] max_y;
      logic        canvas_empty;
      logic [16:0] covered_count;
      logic [7:0]  read_blue;
      logic [7:0]  read_green;
      logic [7:0]  read_red;
      logic        read_covered;
   } rsp_type;
endpackage

// ----- design/mcc_front.sv -----
// Front end: decodes one request into a classified command, one register stage.
module mcc_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [1:0] op,
   input  logic signed [15:0] pose_x,
   input  logic signed [15:0] pose_y,
   input  logic [11:0] col,
   input  logic [11:0] row,
   input  logic [23:0] colour,
   input  logic last,
   input  logic [12:0] frame_width,
   input  logic [12:0] frame_height,
   output logic out_valid,
   input  logic out_ready,
   output mcc_pkg::cmd_type out_cmd
);
   import mcc_pkg::*;

   logic valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic signed [18:0] cx, cy, ax, ay, ex, ey, cx0, cy0, cx1, cy1;

   assign in_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_cmd = cmd_ff;

   always_comb begin
      cx = 19'(pose_x) + 19'(signed'({1'b0, col})) + 19'(ORIGIN);
      cy = 19'(pose_y) + 19'(signed'({1'b0, row})) + 19'(ORIGIN);
      ax = 19'(pose_x) + 19'(ORIGIN);
      ay = 19'(pose_y) + 19'(ORIGIN);
      ex = ax + 19'(signed'({1'b0, frame_width}));
      ey = ay + 19'(signed'({1'b0, frame_height}));
      cx0 = (ax < 0) ? 19'sd0 : ax;
      cy0 = (ay < 0) ? 19'sd0 : ay;
      cx1 = (ex > 19'(CANVAS_SIDE)) ? 19'(CANVAS_SIDE) : ex;
      cy1 = (ey > 19'(CANVAS_SIDE)) ? 19'(CANVAS_SIDE) : ey;
      cmd_in.op = op;
      cmd_in.on_canvas = cx >= 0 && cx < 19'(CANVAS_SIDE) && cy >= 0 && cy < 19'(CANVAS_SIDE);
      cmd_in.cell_addr = {cy[SIDE_W-1:0], cx[SIDE_W-1:0]};
      cmd_in.colour = colour;
      cmd_in.clip_ok = cx0 < cx1 && cy0 < cy1;
      cmd_in.write_px = op == OP_COMPOSITE && cmd_in.on_canvas
                        && {1'b0, col} < frame_width && {1'b0, row} < frame_height;
      cmd_in.box_upd = op == OP_COMPOSITE && last && cmd_in.clip_ok;
      cmd_in.px = 17'(pose_x);
      cmd_in.py = 17'(pose_y);
      cmd_in.fx1 = 17'(pose_x) + 17'(signed'({1'b0, frame_width[12:0]}));
      cmd_in.fy1 = 17'(pose_y) + 17'(signed'({1'b0, frame_height[12:0]}));
      // clipped bounds lie in 0..CANVAS_SIDE once the rectangle is valid
      cmd_in.x0 = cx0[SIDE_W:0];
      cmd_in.y0 = cy0[SIDE_W:0];
      cmd_in.x1 = cx1[SIDE_W:0];
      cmd_in.y1 = cy1[SIDE_W:0];
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (in_valid && in_ready) cmd_ff <= cmd_in;
   end
endmodule

// ----- design/mcc_queue.sv -----
// Two-entry command queue between front and back.
module mcc_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  mcc_pkg::cmd_type in_cmd,
   output logic out_valid,
   input  logic out_ready,
   output mcc_pkg::cmd_type out_cmd
);
   import mcc_pkg::*;
   `include "assert_macros.svh"

   cmd_type slot_ff [2];
   logic rd_ff, wr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= in_cmd;
   end

   `ASSERT_IMPLY(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 2'd2)
   `ASSERT_IMPLY(a_ptr_match, clock, reset, cnt_ff == 2'd0 || cnt_ff == 2'd2, rd_ff == wr_ff)
endmodule

// ----- design/mcc_back.sv -----
// Back end: canvas stores, box state, scan and clear sequencer, result register.
module mcc_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  mcc_pkg::cmd_type in_cmd,
   output logic rsp_valid,
   input  logic rsp_ready,
   output mcc_pkg::rsp_type rsp
);
   import mcc_pkg::*;
   `include "assert_macros.svh"

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_CLEAR = 3'd4;
   localparam logic [2:0] ST_OUT = 3'd5;

   logic [23:0] colour_mem [CELLS];
   logic        cover_mem [CELLS];
   logic [23:0] col_rd_ff;
   logic        cov_rd_ff;

   logic [2:0] state_ff, state_in;
   cmd_type cmd_ff;
   logic empty_ff;
   logic signed [16:0] bl_ff, bt_ff, br_ff, bb_ff;
   logic [SIDE_W-1:0] sx_ff, sy_ff;
   logic scan_rd_ff;          // a scan read issued last cycle
   logic [16:0] cnt_ff;
   logic [CELL_W-1:0] clr_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic start;
   logic [CELL_W-1:0] rd_addr;
   logic rd_en, cov_we, cov_wd, col_we;
   logic [CELL_W-1:0] wr_addr;
   logic [23:0] col_wd;
   logic scan_end;

   assign in_ready = state_ff == ST_IDLE && !rsp_valid_ff;
   assign start = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;
   assign scan_end = {1'b0, sx_ff} + 1'b1 == cmd_ff.x1 && {1'b0, sy_ff} + 1'b1 == cmd_ff.y1;

   function automatic logic [7:0] avg(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   always_comb begin
      rd_en = 1'b0;
      rd_addr = in_cmd.cell_addr;
      if (start) rd_en = 1'b1;
      if (state_ff == ST_SCAN) begin
         rd_en = 1'b1;
         rd_addr = {sy_ff, sx_ff};
      end
      cov_we = 1'b0;
      cov_wd = 1'b0;
      col_we = 1'b0;
      wr_addr = cmd_ff.cell_addr;
      col_wd = cmd_ff.colour;
      if (state_ff == ST_LOOK && cmd_ff.write_px) begin
         cov_we = 1'b1;
         cov_wd = 1'b1;
         col_we = 1'b1;
         if (cov_rd_ff)
            col_wd = {avg(col_rd_ff[23:16], cmd_ff.colour[23:16]),
                      avg(col_rd_ff[15:8], cmd_ff.colour[15:8]),
                      avg(col_rd_ff[7:0], cmd_ff.colour[7:0])};
      end
      if (state_ff == ST_CLEAR) begin
         cov_we = 1'b1;
         wr_addr = clr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         col_rd_ff <= colour_mem[rd_addr];
         cov_rd_ff <= cover_mem[rd_addr];
      end
      if (cov_we) cover_mem[wr_addr] <= cov_wd;
      if (col_we) colour_mem[wr_addr] <= col_wd;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (in_cmd.op == OP_CLEAR) state_in = ST_CLEAR;
               else if (in_cmd.op == OP_QUERY)
                  state_in = (in_cmd.clip_ok && !empty_ff) ? ST_SCAN : ST_OUT;
               else state_in = ST_LOOK;
            end
         end
         ST_LOOK: state_in = ST_OUT;
         ST_SCAN: if (scan_end) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_OUT;
         ST_CLEAR: begin
            // only a clear request answers; the post-reset sweep goes straight to idle
            if (clr_ff == CELL_W'(CELLS - 1))
               state_in = (cmd_ff.op == OP_CLEAR) ? ST_OUT : ST_IDLE;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;   // coverage is swept clear after reset
         empty_ff <= 1'b1;
         bl_ff <= '0;
         bt_ff <= '0;
         br_ff <= '1;
         bb_ff <= '1;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         scan_rd_ff <= 1'b0;
         cmd_ff.op <= OP_READ;   // post-reset sweep emits no result
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         scan_rd_ff <= state_ff == ST_SCAN;
         if (scan_rd_ff && cov_rd_ff && cnt_ff != COUNT_MAX) cnt_ff <= cnt_ff + 1'b1;
         if (start) begin
            cmd_ff <= in_cmd;
            cnt_ff <= '0;
            sx_ff <= in_cmd.x0[SIDE_W-1:0];
            sy_ff <= in_cmd.y0[SIDE_W-1:0];
            clr_ff <= '0;
         end
         if (state_ff == ST_SCAN) begin
            if ({1'b0, sx_ff} + 1'b1 == cmd_ff.x1) begin
               sx_ff <= cmd_ff.x0[SIDE_W-1:0];
               sy_ff <= sy_ff + 1'b1;
            end else sx_ff <= sx_ff + 1'b1;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == CELL_W'(CELLS - 1)) begin
               empty_ff <= 1'b1;
               bl_ff <= '0;
               bt_ff <= '0;
               br_ff <= '1;
               bb_ff <= '1;
            end
         end
         if (state_ff == ST_LOOK && cmd_ff.box_upd) begin
            empty_ff <= 1'b0;
            bl_ff <= (empty_ff || cmd_ff.px < bl_ff) ? cmd_ff.px : bl_ff;
            bt_ff <= (empty_ff || cmd_ff.py < bt_ff) ? cmd_ff.py : bt_ff;
            br_ff <= (empty_ff || cmd_ff.fx1 > br_ff) ? cmd_ff.fx1 : br_ff;
            bb_ff <= (empty_ff || cmd_ff.fy1 > bb_ff) ? cmd_ff.fy1 : bb_ff;
         end
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
      end
      if (state_ff == ST_OUT) begin
         rsp_ff.min_x <= bl_ff;
         rsp_ff.min_y <= bt_ff;
         rsp_ff.max_x <= br_ff;
         rsp_ff.max_y <= bb_ff;
         rsp_ff.canvas_empty <= empty_ff;
         rsp_ff.covered_count <= cmd_ff.op == OP_QUERY ? cnt_ff : '0;
         if (cmd_ff.op == OP_READ && cmd_ff.on_canvas && cov_rd_ff) begin
            rsp_ff.read_blue <= col_rd_ff[7:0];
            rsp_ff.read_green <= col_rd_ff[15:8];
            rsp_ff.read_red <= col_rd_ff[23:16];
            rsp_ff.read_covered <= 1'b1;
         end else begin
            rsp_ff.read_blue <= '0;
            rsp_ff.read_green <= '0;
            rsp_ff.read_red <= '0;
            rsp_ff.read_covered <= 1'b0;
         end
      end
   end

   `ASSERT_NEXT(a_look_out, clock, reset, state_ff == ST_LOOK, state_ff == ST_OUT)
   `ASSERT_IMPLY(a_no_start_busy, clock, reset, start, state_ff == ST_IDLE && !rsp_valid_ff)
endmodule

// ----- design/mosaic_canvas_compositor_core.sv -----
// Top level of the mosaic canvas compositor.
// Flow: a request passes the front register and a queue slot to the back end, where a
// composite or read passes LOOK and OUT, a query scans its clipped rectangle, and a
// clear sweeps every cell. Throughput: one item in flight in the back end, which takes
// no new one until its response is taken; scan and clear sweeps go one cell per cycle.
// Reset: synchronous, active high; afterwards the coverage store is swept clear over all
// CELLS (65536) cells; up to three requests queue meanwhile; csr writes always land.
module mosaic_canvas_compositor_core (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: pose_x[15:0], pose_y[31:16], col[43:32], row[55:44], blue[63:56],
   //        green[71:64], red[79:72]
   input  logic [79:0] req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0] req_tuser,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: min_x[16:0], min_y[33:17], max_x[50:34], max_y[67:51],
   //        canvas_empty[68], covered_count[85:69], read_blue[93:86],
   //        read_green[101:94], read_red[109:102], read_covered[110], zero[111]
   output logic [111:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [12:0] csr_data
);
   import mcc_pkg::*;

   logic [12:0] fw_ff, fh_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   cmd_type f_cmd, b_cmd;
   rsp_type r;

   // csr writes land immediately
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= 13'd640;
         fh_ff <= 13'd480;
      end else if (csr_valid) begin
         if (csr_index == CSR_FRAME_WIDTH) fw_ff <= csr_data;
         if (csr_index == CSR_FRAME_HEIGHT) fh_ff <= csr_data;
      end
   end

   mcc_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .op(req_tuser),
      .pose_x(req_tdata[15:0]), .pose_y(req_tdata[31:16]),
      .col(req_tdata[43:32]), .row(req_tdata[55:44]),
      .colour({req_tdata[79:72], req_tdata[71:64], req_tdata[63:56]}),
      .last(req_tlast),
      .frame_width(fw_ff), .frame_height(fh_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_cmd(f_cmd)
   );

   mcc_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
   );

   mcc_back u_back (
      .clock, .reset,
      .in_valid(b_valid), .in_ready(b_ready), .in_cmd(b_cmd),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(r)
   );

   assign rsp_tdata = {1'b0, r.read_covered, r.read_red, r.read_green, r.read_blue,
                       r.covered_count, r.canvas_empty, r.max_y, r.max_x, r.min_y,
                       r.min_x};
endmodule
